@@ sv/pfgr_pkg.sv @@
// ----------------------------------------------------------------------------
// pfgr_pkg
// Shared types and codes for the polygon flag grid rasterizer.
// ----------------------------------------------------------------------------
package pfgr_pkg;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_MARK   = 3'd1,
    CMD_FILL   = 3'd2,
    CMD_INVERT = 3'd3,
    CMD_WRITE  = 3'd4,
    CMD_OR     = 3'd5,
    CMD_READ   = 3'd6,
    CMD_NONE   = 3'd7
  } cmd_t;

  localparam logic [2:0] REG_GRID_COLS = 3'd0;
  localparam logic [2:0] REG_GRID_ROWS = 3'd1;
  localparam logic [2:0] REG_CELL_SIZE = 3'd2;
  localparam logic [2:0] REG_ORIGIN_X  = 3'd3;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SWEEP_RD,
    ST_SWEEP_WR,
    ST_CELL_RD,
    ST_CELL_WR,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_SUM,
    ST_SQRT,
    ST_MUL_X,
    ST_MX_LD,
    ST_MUL_Y,
    ST_MY_LD,
    ST_STEPS_LD,
    ST_DIV,
    ST_PT_SETUP,
    ST_PT_X,
    ST_PT_Y,
    ST_PT_RD,
    ST_PT_WR,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    DOP_MX,
    DOP_MY,
    DOP_STEPS,
    DOP_CX,
    DOP_CY
  } div_op_t;

  typedef enum logic [1:0] {
    PH_START,
    PH_END,
    PH_WALK
  } pt_phase_t;

  // Q.16 point position and its offset from the grid corner
  localparam int PX_W = 50;
  localparam int NX_W = 52;

endpackage

@@ sv/polygon_flag_grid_rasterizer.sv @@
// ----------------------------------------------------------------------------
// polygon_flag_grid_rasterizer
// Bit grid of cells with clear, segment mark, column fill, invert and
// single cell write / OR / read, driven by one sequencer around a shared
// multiplier, a shared bit-serial divider and a bit-serial square root.
// ----------------------------------------------------------------------------
//  channel | ports                          | moves
//  --------+--------------------------------+------------------------------
//  in      | in_valid / in_ready, in_*      | one command word
//  out     | out_valid / out_ready, out_*   | one result word per command
//  cfg     | cfg_valid / cfg_ready          | register index + data
//
//  Fill and invert read one column word and write it back through the
//  single memory port for each active column. Mark segment: set-up runs a
//  33-step square root and three 64-step divides (the divides are skipped
//  for a zero-length segment), then each of (steps + 3) points takes a
//  6-step divide per axis when the point lies inside the grid.
//  Synchronous active-low reset; the valid bits clear the grid at once.
//  in_ready is high only when idle; a finished word waits in the output
//  register while the next command is taken.
// ----------------------------------------------------------------------------
module polygon_flag_grid_rasterizer import pfgr_pkg::*; #(
  parameter int GRID_W        = 64,
  parameter int GRID_H        = 64,
  parameter int MAX_SEG_STEPS = 1023
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_cmd,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic signed [31:0] in_end_x,
  input  logic signed [31:0] in_end_y,
  input  logic signed [10:0] in_col_index,
  input  logic signed [10:0] in_row_index,
  input  logic               in_cell_bit,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_flag_out,
  output logic               out_inverted_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int CW  = (GRID_W > 1) ? $clog2(GRID_W) : 1;
  localparam int RW  = (GRID_H > 1) ? $clog2(GRID_H) : 1;
  localparam int NCW = $clog2(GRID_W + 1);
  localparam int NRW = $clog2(GRID_H + 1);
  localparam int SW  = $clog2(MAX_SEG_STEPS + 1);

  // configuration
  logic [6:0]         grid_cols_r, grid_rows_r;
  logic [23:0]        cell_size_r;
  logic [31:0]        origin_x_r, origin_y_r;

  // control
  state_t             state_r, state_nxt;
  logic               out_valid_r, out_flag_r, out_inv_r;
  logic               inv_r;
  logic [GRID_W-1:0]  vld_r;

  // command word
  cmd_t               cmd_r;
  logic signed [31:0] sx_r, sy_r, ex_r, ey_r;
  logic [CW-1:0]      ci_r;
  logic [RW-1:0]      ri_r;
  logic               bit_r, flag_r;
  logic [32:0]        adx_r, ady_r;
  logic               sgx_r, sgy_r;

  // arithmetic
  logic [32:0]        mul_a, mul_b;
  logic [65:0]        mul_r, sum_r, sq_r;
  logic [33:0]        rt_rem_r;
  logic [32:0]        root_r;
  logic [32:0]        div_r_r, div_d_r;
  logic [63:0]        div_n_r, div_q_r;
  logic [5:0]         cnt_r;
  div_op_t            div_op_r;
  logic signed [32:0] ix_r, iy_r;
  logic [SW-1:0]      steps_r, i_r;
  logic signed [PX_W-1:0] px_r, py_r;
  pt_phase_t          ph_r;
  logic [CW-1:0]      cx_r, k_r;
  logic [RW-1:0]      cy_r;

  // memory
  logic [GRID_H-1:0]  mem [GRID_W];
  logic [GRID_H-1:0]  rdata_r, rd_eff, mem_wdata;
  logic [CW-1:0]      mem_addr;
  logic               mem_we;

  // derived
  logic [NCW-1:0]     nc, nc_m1;
  logic [NRW-1:0]     nr, nr_m1;
  logic [23:0]        csz;
  logic [GRID_H-1:0]  rm;
  logic               accept, out_free, grid_empty, in_rng;
  logic signed [32:0] dx, dy;

  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_flag_out     = out_inv_r ? out_flag_r : out_flag_r;
  assign out_inverted_out = out_inv_r;
  assign accept           = in_valid && in_ready;
  assign out_free         = !out_valid_r || out_ready;

  assign nc    = (32'(grid_cols_r) < GRID_W) ? NCW'(grid_cols_r) : NCW'(GRID_W);
  assign nr    = (32'(grid_rows_r) < GRID_H) ? NRW'(grid_rows_r) : NRW'(GRID_H);
  assign nc_m1 = nc - NCW'(1);
  assign nr_m1 = nr - NRW'(1);
  assign csz   = (cell_size_r == 24'd0) ? 24'd1 : cell_size_r;
  assign grid_empty = (nc == '0) || (nr == '0);

  always_comb begin
    for (int r = 0; r < GRID_H; r++) begin
      rm[r] = (32'(r) < 32'(nr));
    end
  end

  assign in_rng = !in_col_index[10] && ({1'b0, in_col_index[9:0]} < 11'(nc)) &&
                  !in_row_index[10] && ({1'b0, in_row_index[9:0]} < 11'(nr));
  assign dx = {in_end_x[31], in_end_x} - {in_start_x[31], in_start_x};
  assign dy = {in_end_y[31], in_end_y} - {in_start_y[31], in_start_y};

  // even-odd fill of one column word: inclusive prefix parity; an unpaired
  // last opener keeps only the rows below the topmost set cell
  function automatic logic [GRID_H-1:0] fill_word(input logic [GRID_H-1:0] w,
                                                  input logic [GRID_H-1:0] m);
    logic [GRID_H-1:0] wm, p, h, keep;
    wm = w & m;
    p  = wm;
    h  = wm;
    for (int i = 0; i < 6; i++) begin
      p = p ^ (p << (1 << i));
      h = h | (h >> (1 << i));
    end
    // h marks every row at or below the topmost set cell
    keep = p[GRID_H-1] ? (h >> 1) : '1;
    return w | (p & m & keep);
  endfunction

  // square root step
  logic [35:0] rt_t, rt_trial, rt_diff;
  logic        rt_ge;
  logic [33:0] rt_rem_nxt;
  logic [32:0] root_nxt;
  assign rt_t       = {rt_rem_r, sq_r[65:64]};
  assign rt_trial   = {1'b0, root_r, 2'b01};
  assign rt_diff    = rt_t - rt_trial;
  assign rt_ge      = rt_t >= rt_trial;
  assign rt_rem_nxt = rt_ge ? rt_diff[33:0] : rt_t[33:0];
  assign root_nxt   = {root_r[31:0], rt_ge};

  // divider step
  logic [33:0] div_t, div_diff;
  logic        div_ge;
  logic [32:0] div_rem_nxt;
  logic [63:0] div_q_nxt;
  assign div_t       = {div_r_r, div_n_r[63]};
  assign div_diff    = div_t - {1'b0, div_d_r};
  assign div_ge      = div_t >= {1'b0, div_d_r};
  assign div_rem_nxt = div_ge ? div_diff[32:0] : div_t[32:0];
  assign div_q_nxt   = {div_q_r[62:0], div_ge};

  // point offset from the grid corner, Q.16
  logic signed [NX_W-1:0] nx_x, nx_y;
  logic                   big_x, big_y;
  assign nx_x  = {{2{px_r[PX_W-1]}}, px_r} - {{12{origin_x_r[31]}}, origin_x_r, 8'b0};
  assign nx_y  = {{2{py_r[PX_W-1]}}, py_r} - {{12{origin_y_r[31]}}, origin_y_r, 8'b0};
  assign big_x = nx_x[NX_W-2:0] >= 51'({csz, 14'b0});
  assign big_y = nx_y[NX_W-2:0] >= 51'({csz, 14'b0});

  function automatic logic [CW-1:0] clamp_col(input logic [5:0] q, input logic [NCW-1:0] lm);
    return (32'(q) > 32'(lm)) ? CW'(lm) : CW'(q);
  endfunction

  function automatic logic [RW-1:0] clamp_row(input logic [5:0] q, input logic [NRW-1:0] lm);
    return (32'(q) > 32'(lm)) ? RW'(lm) : RW'(q);
  endfunction

  assign rd_eff = vld_r[mem_addr] ? rdata_r : '0;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_t'(in_cmd))
            CMD_CLEAR:  state_nxt = ST_CLEAR;
            CMD_MARK:   state_nxt = grid_empty ? ST_DONE : ST_SQ_X;
            CMD_FILL,
            CMD_INVERT: state_nxt = (nc == '0) ? ST_DONE : ST_SWEEP_RD;
            CMD_WRITE,
            CMD_OR,
            CMD_READ:   state_nxt = in_rng ? ST_CELL_RD : ST_DONE;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_CLEAR:    state_nxt = ST_DONE;
      ST_SWEEP_RD: state_nxt = ST_SWEEP_WR;
      ST_SWEEP_WR: state_nxt = (32'(k_r) == 32'(nc_m1)) ? ST_DONE : ST_SWEEP_RD;
      ST_CELL_RD:  state_nxt = ST_CELL_WR;
      ST_CELL_WR:  state_nxt = ST_DONE;
      ST_SQ_X:     state_nxt = ST_SQ_Y;
      ST_SQ_Y:     state_nxt = ST_SQ_SUM;
      ST_SQ_SUM:   state_nxt = ST_SQRT;
      ST_SQRT: begin
        if (cnt_r == '0) begin
          state_nxt = (root_nxt == '0) ? ST_PT_SETUP : ST_MUL_X;
        end
      end
      ST_MUL_X:    state_nxt = ST_MX_LD;
      ST_MX_LD:    state_nxt = ST_DIV;
      ST_MUL_Y:    state_nxt = ST_MY_LD;
      ST_MY_LD:    state_nxt = ST_DIV;
      ST_STEPS_LD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == '0) begin
          unique case (div_op_r)
            DOP_MX:    state_nxt = ST_MUL_Y;
            DOP_MY:    state_nxt = ST_STEPS_LD;
            DOP_STEPS: state_nxt = ST_PT_SETUP;
            DOP_CX:    state_nxt = ST_PT_Y;
            default:   state_nxt = ST_PT_RD;
          endcase
        end
      end
      ST_PT_SETUP: state_nxt = ST_PT_X;
      ST_PT_X:     state_nxt = (nx_x[NX_W-1] || big_x) ? ST_PT_Y : ST_DIV;
      ST_PT_Y:     state_nxt = (nx_y[NX_W-1] || big_y) ? ST_PT_RD : ST_DIV;
      ST_PT_RD:    state_nxt = ST_PT_WR;
      ST_PT_WR:    state_nxt = (ph_r == PH_WALK && i_r == steps_r) ? ST_DONE : ST_PT_X;
      ST_DONE:     state_nxt = out_free ? ST_IDLE : ST_DONE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    mul_a     = '0;
    mul_b     = '0;
    mem_we    = 1'b0;
    mem_wdata = rd_eff;
    mem_addr  = cx_r;
    unique case (state_r)
      ST_SQ_X: begin
        mul_a = adx_r;
        mul_b = adx_r;
      end
      ST_SQ_Y: begin
        mul_a = ady_r;
        mul_b = ady_r;
      end
      ST_MUL_X: begin
        mul_a = adx_r;
        mul_b = {9'b0, csz};
      end
      ST_MUL_Y: begin
        mul_a = ady_r;
        mul_b = {9'b0, csz};
      end
      ST_SWEEP_RD: mem_addr = k_r;
      ST_SWEEP_WR: begin
        mem_addr  = k_r;
        mem_we    = 1'b1;
        mem_wdata = (cmd_r == CMD_FILL) ? fill_word(rd_eff, rm) : (rd_eff ^ rm);
      end
      ST_CELL_RD: mem_addr = ci_r;
      ST_CELL_WR: begin
        mem_addr = ci_r;
        mem_we   = (cmd_r == CMD_WRITE) || (cmd_r == CMD_OR && bit_r);
        if (cmd_r == CMD_WRITE && !bit_r) begin
          mem_wdata = rd_eff & ~(GRID_H'(1) << ri_r);
        end else begin
          mem_wdata = rd_eff | (GRID_H'(1) << ri_r);
        end
      end
      ST_PT_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rd_eff | (GRID_H'(1) << cy_r);
      end
      default: ;
    endcase
  end

  // grid memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_r <= mem[mem_addr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r <= 7'd64;
      grid_rows_r <= 7'd64;
      cell_size_r <= 24'd256;
      origin_x_r  <= '0;
      origin_y_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GRID_COLS: grid_cols_r <= cfg_data[6:0];
        REG_GRID_ROWS: grid_rows_r <= cfg_data[6:0];
        REG_CELL_SIZE: cell_size_r <= cfg_data[23:0];
        REG_ORIGIN_X:  origin_x_r  <= cfg_data;
        REG_ORIGIN_Y:  origin_y_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      out_flag_r  <= 1'b0;
      out_inv_r   <= 1'b0;
      inv_r       <= 1'b0;
      vld_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept && cmd_t'(in_cmd) == CMD_INVERT) begin
        inv_r <= !inv_r;
      end
      if (state_r == ST_CLEAR) begin
        inv_r <= 1'b0;
        vld_r <= '0;
      end else if (mem_we) begin
        vld_r[mem_addr] <= 1'b1;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
        out_flag_r  <= flag_r;
        out_inv_r   <= inv_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
    if (accept) begin
      cmd_r  <= cmd_t'(in_cmd);
      sx_r   <= in_start_x;
      sy_r   <= in_start_y;
      ex_r   <= in_end_x;
      ey_r   <= in_end_y;
      ci_r   <= in_col_index[CW-1:0];
      ri_r   <= in_row_index[RW-1:0];
      bit_r  <= in_cell_bit;
      flag_r <= 1'b0;
      k_r    <= '0;
      adx_r  <= dx[32] ? -dx : dx;
      ady_r  <= dy[32] ? -dy : dy;
      sgx_r  <= dx[32];
      sgy_r  <= dy[32];
    end
    unique case (state_r)
      ST_SWEEP_WR: k_r <= k_r + CW'(1);
      ST_CELL_WR:  flag_r <= (cmd_r == CMD_READ) && rd_eff[ri_r];
      ST_SQ_Y:     sum_r <= mul_r;
      ST_SQ_SUM: begin
        sq_r     <= mul_r + sum_r;
        rt_rem_r <= '0;
        root_r   <= '0;
        cnt_r    <= 6'd32;
      end
      ST_SQRT: begin
        sq_r     <= {sq_r[63:0], 2'b00};
        rt_rem_r <= rt_rem_nxt;
        root_r   <= root_nxt;
        cnt_r    <= cnt_r - 6'd1;
        if (cnt_r == '0 && root_nxt == '0) begin
          ix_r    <= '0;
          iy_r    <= '0;
          steps_r <= '0;
        end
      end
      ST_MX_LD, ST_MY_LD: begin
        div_r_r  <= '0;
        div_n_r  <= {mul_r[56:0], 7'b0};
        div_d_r  <= root_r;
        div_q_r  <= '0;
        cnt_r    <= 6'd63;
        div_op_r <= (state_r == ST_MX_LD) ? DOP_MX : DOP_MY;
      end
      ST_STEPS_LD: begin
        div_r_r  <= '0;
        div_n_r  <= {30'b0, root_r, 1'b0};
        div_d_r  <= {9'b0, csz};
        div_q_r  <= '0;
        cnt_r    <= 6'd63;
        div_op_r <= DOP_STEPS;
      end
      ST_DIV: begin
        div_r_r <= div_rem_nxt;
        div_n_r <= {div_n_r[62:0], 1'b0};
        div_q_r <= div_q_nxt;
        cnt_r   <= cnt_r - 6'd1;
        if (cnt_r == '0) begin
          unique case (div_op_r)
            DOP_MX: ix_r <= sgx_r ? -$signed({1'b0, div_q_nxt[31:0]})
                                  : $signed({1'b0, div_q_nxt[31:0]});
            DOP_MY: iy_r <= sgy_r ? -$signed({1'b0, div_q_nxt[31:0]})
                                  : $signed({1'b0, div_q_nxt[31:0]});
            DOP_STEPS: steps_r <= (div_q_nxt > 64'(MAX_SEG_STEPS)) ?
                                  SW'(MAX_SEG_STEPS) : div_q_nxt[SW-1:0];
            DOP_CX: cx_r <= clamp_col(div_q_nxt[5:0], nc_m1);
            default: cy_r <= clamp_row(div_q_nxt[5:0], nr_m1);
          endcase
        end
      end
      ST_PT_SETUP: begin
        px_r <= {{10{sx_r[31]}}, sx_r, 8'b0};
        py_r <= {{10{sy_r[31]}}, sy_r, 8'b0};
        ph_r <= PH_START;
        i_r  <= '0;
      end
      ST_PT_X: begin
        if (nx_x[NX_W-1]) begin
          cx_r <= '0;
        end else if (big_x) begin
          cx_r <= clamp_col(6'h3f, nc_m1);
        end else begin
          // quotient below 64: seed with n/64, six bits to go
          div_r_r  <= nx_x[38:6];
          div_n_r  <= {nx_x[5:0], 58'b0};
          div_d_r  <= {1'b0, csz, 8'b0};
          div_q_r  <= '0;
          cnt_r    <= 6'd5;
          div_op_r <= DOP_CX;
        end
      end
      ST_PT_Y: begin
        if (nx_y[NX_W-1]) begin
          cy_r <= '0;
        end else if (big_y) begin
          cy_r <= clamp_row(6'h3f, nr_m1);
        end else begin
          div_r_r  <= nx_y[38:6];
          div_n_r  <= {nx_y[5:0], 58'b0};
          div_d_r  <= {1'b0, csz, 8'b0};
          div_q_r  <= '0;
          cnt_r    <= 6'd5;
          div_op_r <= DOP_CY;
        end
      end
      ST_PT_WR: begin
        unique case (ph_r)
          PH_START: begin
            ph_r <= PH_END;
            px_r <= {{10{ex_r[31]}}, ex_r, 8'b0};
            py_r <= {{10{ey_r[31]}}, ey_r, 8'b0};
          end
          PH_END: begin
            ph_r <= PH_WALK;
            px_r <= {{10{sx_r[31]}}, sx_r, 8'b0};
            py_r <= {{10{sy_r[31]}}, sy_r, 8'b0};
            i_r  <= '0;
          end
          default: begin
            i_r  <= i_r + SW'(1);
            px_r <= px_r + {{17{ix_r[32]}}, ix_r};
            py_r <= py_r + {{17{iy_r[32]}}, iy_r};
          end
        endcase
      end
      default: ;
    endcase
  end

  a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_SWEEP_WR || state_r == ST_CELL_WR || state_r == ST_PT_WR))
    else $error("grid write outside a write state");

  a_col_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PT_RD |-> 32'(cx_r) < 32'(nc) && 32'(cy_r) < 32'(nr))
    else $error("marked cell outside the active grid");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |=> !$past(accept))
    else $error("command taken while the divider runs");

endmodule
